// File: rtl/stbag_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stbag_pkg
// Shared widths and register indexes for the scaled blit address generator.
// ----------------------------------------------------------------------------
package stbag_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int REG_W     = $clog2(MAX_DIM) + 1;
  localparam int REG_IDX_W = 3;
  localparam int COORD_W   = 16;
  localparam int IDX_W     = 24;
  localparam int DIV_W     = COORD_W + 1;
  localparam int QUO_W     = REG_W;
  localparam int NUM_W     = COORD_W + REG_W;
  localparam int MUL_W     = COORD_W + REG_W + 1;

  localparam logic [REG_IDX_W-1:0] REG_CLIP_LEFT    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CLIP_TOP     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CLIP_RIGHT   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CLIP_BOTTOM  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LINE_STRIDE  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TEX_WIDTH    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_TEX_HEIGHT   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_ALIGNED_MODE = 3'd7;

  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

endpackage
`default_nettype wire

// File: rtl/stbag_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stbag_divider
// Radix-2 restoring divider, one quotient bit per cycle. The quotient is known
// to fit in QUO_W bits, so the upper numerator bits seed the remainder.
// ----------------------------------------------------------------------------
module stbag_divider (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [stbag_pkg::NUM_W-1:0] num,
  input  wire logic [stbag_pkg::DIV_W-1:0] den,
  output logic                             done,
  output logic [stbag_pkg::QUO_W-1:0]      quot
);

  localparam int CNT_W = $clog2(stbag_pkg::QUO_W + 1);

  logic                        running;
  logic [CNT_W-1:0]            cnt;
  logic [stbag_pkg::DIV_W-1:0] rem;
  logic [stbag_pkg::DIV_W-1:0] den_q;
  logic [stbag_pkg::QUO_W-1:0] shreg;
  logic [stbag_pkg::DIV_W:0]   trial;
  logic [stbag_pkg::DIV_W:0]   diff;
  logic                        fits;

  assign trial = {rem, shreg[stbag_pkg::QUO_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(stbag_pkg::QUO_W);
        rem     <= stbag_pkg::DIV_W'(num[stbag_pkg::NUM_W-1:stbag_pkg::QUO_W]);
        shreg   <= num[stbag_pkg::QUO_W-1:0];
        den_q   <= den;
      end else if (running) begin
        rem   <= fits ? diff[stbag_pkg::DIV_W-1:0] : trial[stbag_pkg::DIV_W-1:0];
        shreg <= {shreg[stbag_pkg::QUO_W-2:0], 1'b0};
        quot  <= {quot[stbag_pkg::QUO_W-2:0], fits};
        cnt   <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/scaled_texture_blit_address_gen.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scaled_texture_blit_address_gen
// Nearest-neighbor blit address walker: clips a rectangle to the canvas and
// emits destination and source pixel indices in row-major order.
// ----------------------------------------------------------------------------
//   channel   handshake              payload
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//   in        in_valid / in_stall    req_type, rect_left/top/right/bottom
//   out       out_valid / out_stall  dest_index, src_index, last
//
// A start beat, or an advance beat with no walk in progress, leaves the block
// idle. In a walk, an advance beat holds in_stall through ST_DEST, ST_DEST_W,
// in scaled mode ST_MU, ST_MU_W, ST_DU, ST_MV, ST_MV_W, ST_DV, then ST_SRC and
// ST_SRC_W on one shared multiply-add and a divider retiring one bit per cycle.
// Reset is synchronous; the block comes out of reset idle with no walk.
// A stalled result holds in the output register; the next result waits for it.
// ----------------------------------------------------------------------------
module scaled_texture_blit_address_gen (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [stbag_pkg::REG_IDX_W-1:0]     cfg_index,
  input  wire logic [stbag_pkg::REG_W-1:0]         cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                req_type,
  input  wire logic signed [stbag_pkg::COORD_W-1:0] rect_left,
  input  wire logic signed [stbag_pkg::COORD_W-1:0] rect_top,
  input  wire logic signed [stbag_pkg::COORD_W-1:0] rect_right,
  input  wire logic signed [stbag_pkg::COORD_W-1:0] rect_bottom,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [stbag_pkg::IDX_W-1:0]              dest_index,
  output logic [stbag_pkg::IDX_W-1:0]              src_index,
  output logic                                     last
);

  localparam int CW = stbag_pkg::COORD_W;
  localparam int RW = stbag_pkg::REG_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DEST, ST_DEST_W, ST_MU, ST_MU_W, ST_DU,
    ST_MV, ST_MV_W, ST_DV, ST_SRC, ST_SRC_W
  } state_t;

  state_t state;

  logic [RW-1:0] clip_left, clip_top, clip_right, clip_bottom;
  logic [RW-1:0] line_stride, tex_width, tex_height;
  logic          aligned_mode;

  logic signed [CW-1:0] walk_x, walk_y, span_left, span_right, span_bottom;
  logic signed [CW-1:0] origin_x, origin_y;
  logic [stbag_pkg::DIV_W-1:0] rect_w, rect_h;
  logic                 busy;

  logic [CW-1:0]               u, v;
  logic [stbag_pkg::MUL_W-1:0] prod;
  logic [stbag_pkg::MUL_W-1:0] prod_next;
  logic [CW-1:0]               ma;
  logic [RW-1:0]               mb;
  logic [CW-1:0]               mc;
  logic [stbag_pkg::IDX_W-1:0] dest;

  logic signed [CW:0] rl_e, rt_e, rr_e, rb_e;
  logic signed [CW:0] cl_e, ct_e, cr_e, cb_e;
  logic signed [CW:0] sl_new, st_new, sr_new, sb_new;
  logic               busy_new;
  logic [CW-1:0]      dx, dy;
  logic signed [CW:0] x_inc, y_inc;
  logic               row_end, walk_end;

  logic                        div_start, div_done;
  logic [stbag_pkg::DIV_W-1:0] div_den;
  logic [stbag_pkg::QUO_W-1:0] div_quot;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);

  assign rl_e = {rect_left[CW-1], rect_left};
  assign rt_e = {rect_top[CW-1], rect_top};
  assign rr_e = {rect_right[CW-1], rect_right};
  assign rb_e = {rect_bottom[CW-1], rect_bottom};
  assign cl_e = $signed({{(CW+1-RW){1'b0}}, clip_left});
  assign ct_e = $signed({{(CW+1-RW){1'b0}}, clip_top});
  assign cr_e = $signed({{(CW+1-RW){1'b0}}, clip_right});
  assign cb_e = $signed({{(CW+1-RW){1'b0}}, clip_bottom});

  assign sl_new   = (rl_e > cl_e) ? rl_e : cl_e;
  assign st_new   = (rt_e > ct_e) ? rt_e : ct_e;
  assign sr_new   = (rr_e < cr_e) ? rr_e : cr_e;
  assign sb_new   = (rb_e < cb_e) ? rb_e : cb_e;
  assign busy_new = (sl_new < sr_new) && (st_new < sb_new);

  assign dx       = walk_x - origin_x;
  assign dy       = walk_y - origin_y;
  assign x_inc    = {walk_x[CW-1], walk_x} + (CW+1)'(1);
  assign y_inc    = {walk_y[CW-1], walk_y} + (CW+1)'(1);
  assign row_end  = x_inc >= {span_right[CW-1], span_right};
  assign walk_end = y_inc >= {span_bottom[CW-1], span_bottom};

  always_comb begin
    ma = '0;
    mb = '0;
    mc = '0;
    case (state)
      ST_DEST: begin
        ma = walk_y;
        mb = line_stride;
        mc = walk_x;
      end
      ST_MU: begin
        ma = dx;
        mb = tex_width;
      end
      ST_MV: begin
        ma = dy;
        mb = tex_height;
      end
      ST_SRC: begin
        ma = v;
        mb = tex_width;
        mc = u;
      end
      default: begin
        ma = '0;
      end
    endcase
  end

  assign prod_next = stbag_pkg::MUL_W'(ma) * stbag_pkg::MUL_W'(mb) + stbag_pkg::MUL_W'(mc);

  assign div_start = (state == ST_MU_W) || (state == ST_MV_W);
  assign div_den   = (state == ST_MV_W) ? rect_h : rect_w;

  stbag_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (prod[stbag_pkg::NUM_W-1:0]),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if ((state == ST_DEST) || (state == ST_MU) || (state == ST_MV) || (state == ST_SRC)) begin
      prod <= prod_next;
    end
    if (rst) begin
      state        <= ST_IDLE;
      busy         <= 1'b0;
      out_valid    <= 1'b0;
      clip_left    <= '0;
      clip_top     <= '0;
      clip_right   <= '0;
      clip_bottom  <= '0;
      line_stride  <= RW'(1);
      tex_width    <= RW'(1);
      tex_height   <= RW'(1);
      aligned_mode <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          stbag_pkg::REG_CLIP_LEFT:    clip_left    <= cfg_data;
          stbag_pkg::REG_CLIP_TOP:     clip_top     <= cfg_data;
          stbag_pkg::REG_CLIP_RIGHT:   clip_right   <= cfg_data;
          stbag_pkg::REG_CLIP_BOTTOM:  clip_bottom  <= cfg_data;
          stbag_pkg::REG_LINE_STRIDE:  line_stride  <= cfg_data;
          stbag_pkg::REG_TEX_WIDTH:    tex_width    <= cfg_data;
          stbag_pkg::REG_TEX_HEIGHT:   tex_height   <= cfg_data;
          stbag_pkg::REG_ALIGNED_MODE: aligned_mode <= cfg_data[0];
          default:                     aligned_mode <= aligned_mode;
        endcase
      end

      if (out_valid && !out_stall && (state != ST_SRC_W)) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (req_type == stbag_pkg::REQ_START) begin
              span_left   <= sl_new[CW-1:0];
              span_right  <= sr_new[CW-1:0];
              span_bottom <= sb_new[CW-1:0];
              walk_x      <= sl_new[CW-1:0];
              walk_y      <= st_new[CW-1:0];
              origin_x    <= rect_left;
              origin_y    <= rect_top;
              rect_w      <= rr_e - rl_e;
              rect_h      <= rb_e - rt_e;
              busy        <= busy_new;
            end else if (busy) begin
              state <= ST_DEST;
            end
          end
        end
        ST_DEST: begin
          state <= ST_DEST_W;
        end
        ST_DEST_W: begin
          dest <= prod[stbag_pkg::IDX_W-1:0];
          if (aligned_mode) begin
            u     <= dx;
            v     <= dy;
            state <= ST_SRC;
          end else begin
            state <= ST_MU;
          end
        end
        ST_MU: begin
          state <= ST_MU_W;
        end
        ST_MU_W: begin
          state <= ST_DU;
        end
        ST_DU: begin
          if (div_done) begin
            u     <= CW'(div_quot);
            state <= ST_MV;
          end
        end
        ST_MV: begin
          state <= ST_MV_W;
        end
        ST_MV_W: begin
          state <= ST_DV;
        end
        ST_DV: begin
          if (div_done) begin
            v     <= CW'(div_quot);
            state <= ST_SRC;
          end
        end
        ST_SRC: begin
          state <= ST_SRC_W;
        end
        ST_SRC_W: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            dest_index <= dest;
            src_index  <= prod[stbag_pkg::IDX_W-1:0];
            last       <= row_end && walk_end;
            if (row_end) begin
              walk_x <= span_left;
              walk_y <= y_inc[CW-1:0];
              if (walk_end) begin
                busy <= 1'b0;
              end
            end else begin
              walk_x <= x_inc[CW-1:0];
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/stbag_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stbag_checker
// Port-level checks for the scaled blit address generator.
// ----------------------------------------------------------------------------
module stbag_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic                         req_type,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [stbag_pkg::IDX_W-1:0]  dest_index,
  input wire logic [stbag_pkg::IDX_W-1:0]  src_index,
  input wire logic                         last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(dest_index)
      && $stable(src_index) && $stable(last))
    else $error("stalled output beat changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  a_start_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && req_type == stbag_pkg::REQ_START |=> !in_stall)
    else $error("start beat held the input channel");

  a_out_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("output beat without a pixel computation");

endmodule

bind scaled_texture_blit_address_gen stbag_checker u_stbag_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .req_type   (req_type),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .dest_index (dest_index),
  .src_index  (src_index),
  .last       (last)
);
`default_nettype wire

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: scaled_texture_blit_address_gen regression
// Drives start and advance beats under random back-pressure on both sides,
// predicts each pixel beat from a cycle-free walk of the clipped window or a
// table row and compares destination index, texel index and last flag in order.
// A directed table covers reset, empty windows, idle advances,
// restart mid-walk, index wrap, zero stride and texture size and both modes;
// random register settings and rectangle sequences follow.
// ----------------------------------------------------------------------------
module tb;
  import stbag_pkg::*;

  localparam int PLAN_LEN      = 34;
  localparam int NUM_PHASES    = 10;
  localparam int PHASE_ITEMS   = 70;
  localparam int SETTLE_CYCLES = 48;
  localparam int QUIET_LIMIT   = 4000;
  localparam int PRESSURE_AT   = 150;
  localparam int PRESSURE_HOLD = 400;
  localparam int MAX_WINDOW    = 40;

  typedef struct packed {
    logic [IDX_W-1:0] dest;
    logic [IDX_W-1:0] src;
    logic             lst;
  } pixel_t;

  typedef enum {ROW_CFG, ROW_ITEM} row_kind_e;
  typedef enum {CHK_MODEL, CHK_NONE, CHK_GIVEN} row_check_e;

  typedef struct {
    row_kind_e  kind;
    int         ridx;
    int         rdata;
    int         req;
    int         l, t, r, b;
    row_check_e chk;
    int         dest, src, lst;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic req_type = REQ_START;
  logic signed [COORD_W-1:0] rect_left = '0;
  logic signed [COORD_W-1:0] rect_top = '0;
  logic signed [COORD_W-1:0] rect_right = '0;
  logic signed [COORD_W-1:0] rect_bottom = '0;
  logic out_stall = 1'b0;
  logic cfg_ready;
  logic in_stall;
  logic out_valid;
  logic [IDX_W-1:0] dest_index;
  logic [IDX_W-1:0] src_index;
  logic last;

  scaled_texture_blit_address_gen uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .rect_left(rect_left), .rect_top(rect_top),
    .rect_right(rect_right), .rect_bottom(rect_bottom),
    .out_valid(out_valid), .out_stall(out_stall),
    .dest_index(dest_index), .src_index(src_index), .last(last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow registers and walk state
  logic [REG_W-1:0] shadow_reg [8];
  int pen_x, pen_y, win_l, win_r, win_b, org_x, org_y, rect_wd, rect_ht;
  bit walking;

  pixel_t pixel_q [$];
  int errors, items_sent, results_seen, cfg_sets;
  int tx_calm, rx_hold, rx_calm, quiet;
  bit squeezed;

  row_t plan [PLAN_LEN] = '{
    '{ROW_ITEM, 0, 0, REQ_ADVANCE, 0, 0, 0, 0, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, 0, 0, REQ_START, 0, 0, 4, 4, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, 0, 0, REQ_ADVANCE, 0, 0, 0, 0, CHK_NONE, 0, 0, 0},
    '{ROW_CFG, REG_CLIP_LEFT, 0, 0, 0, 0, 0, 0, CHK_NONE, 0, 0, 0},
    '{ROW_CFG, REG_CLIP_TOP, 0, 0, 0, 0, 0, 0, CHK_NONE, 0, 0, 0},
    '{ROW_CFG, REG_CLIP_RIGHT, 8191, 0, 0, 0, 0, 0, CHK_NONE, 0, 0, 0},
    '{ROW_CFG, REG_CLIP_BOTTOM, 8191, 0, 0, 0, 0, 0, CHK_NONE, 0, 0, 0},
    '{ROW_CFG, REG_LINE_STRIDE, 8191, 0, 0, 0, 0, 0, CHK_NONE, 0, 0, 0},
    '{ROW_CFG, REG_TEX_WIDTH, 8191, 0, 0, 0, 0, 0, CHK_NONE, 0, 0, 0},
    '{ROW_CFG, REG_TEX_HEIGHT, 8191, 0, 0, 0, 0, 0, CHK_NONE, 0, 0, 0},
    '{ROW_CFG, REG_ALIGNED_MODE, 0, 0, 0, 0, 0, 0, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, 0, 0, REQ_START, 0, 0, 1, 1, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, 0, 0, REQ_ADVANCE, 0, 0, 0, 0, CHK_GIVEN, 0, 0, 1},
    '{ROW_ITEM, 0, 0, REQ_ADVANCE, 0, 0, 0, 0, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, 0, 0, REQ_START, 8190, 8190, 32767, 32767, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, 0, 0, REQ_ADVANCE, 0, 0, 0, 0, CHK_GIVEN, 16760832, 0, 1},
    '{ROW_ITEM, 0, 0, REQ_START, -32768, -32768, 32767, 32767, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, 0, 0, REQ_ADVANCE, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0},
    '{ROW_ITEM, 0, 0, REQ_ADVANCE, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0},
    '{ROW_ITEM, 0, 0, REQ_START, 2, 3, 5, 5, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, 0, 0, REQ_ADVANCE, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0},
    '{ROW_ITEM, 0, 0, REQ_ADVANCE, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0},
    '{ROW_ITEM, 0, 0, REQ_ADVANCE, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0},
    '{ROW_ITEM, 0, 0, REQ_ADVANCE, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0},
    '{ROW_ITEM, 0, 0, REQ_ADVANCE, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0},
    '{ROW_ITEM, 0, 0, REQ_ADVANCE, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0},
    '{ROW_CFG, REG_ALIGNED_MODE, 1, 0, 0, 0, 0, 0, CHK_NONE, 0, 0, 0},
    '{ROW_CFG, REG_LINE_STRIDE, 0, 0, 0, 0, 0, 0, CHK_NONE, 0, 0, 0},
    '{ROW_CFG, REG_TEX_WIDTH, 0, 0, 0, 0, 0, 0, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, 0, 0, REQ_START, 5, 6, 7, 7, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, 0, 0, REQ_ADVANCE, 0, 0, 0, 0, CHK_GIVEN, 5, 0, 0},
    '{ROW_ITEM, 0, 0, REQ_ADVANCE, 0, 0, 0, 0, CHK_GIVEN, 6, 1, 1},
    '{ROW_ITEM, 0, 0, REQ_START, 100, 100, 90, 120, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, 0, 0, REQ_ADVANCE, 0, 0, 0, 0, CHK_NONE, 0, 0, 0}
  };

  function automatic bit predict_pixel(input logic kind,
                                       input logic signed [COORD_W-1:0] l, t, r, b,
                                       output pixel_t px);
    int x, y, top;
    longint dx, dy, u, v, d, s;
    px = '0;
    if (kind == REQ_START) begin
      win_l = (int'(l) > int'(shadow_reg[REG_CLIP_LEFT])) ?
              int'(l) : int'(shadow_reg[REG_CLIP_LEFT]);
      top = (int'(t) > int'(shadow_reg[REG_CLIP_TOP])) ?
            int'(t) : int'(shadow_reg[REG_CLIP_TOP]);
      win_r = (int'(r) < int'(shadow_reg[REG_CLIP_RIGHT])) ?
              int'(r) : int'(shadow_reg[REG_CLIP_RIGHT]);
      win_b = (int'(b) < int'(shadow_reg[REG_CLIP_BOTTOM])) ?
              int'(b) : int'(shadow_reg[REG_CLIP_BOTTOM]);
      org_x = int'(l);
      org_y = int'(t);
      rect_wd = int'(r) - int'(l);
      rect_ht = int'(b) - int'(t);
      pen_x = win_l;
      pen_y = top;
      walking = (win_l < win_r) && (top < win_b);
      return 1'b0;
    end
    if (!walking) return 1'b0;
    x = pen_x;
    y = pen_y;
    dx = longint'(x - org_x);
    dy = longint'(y - org_y);
    if (shadow_reg[REG_ALIGNED_MODE][0]) begin
      u = dx;
      v = dy;
    end else begin
      u = dx * longint'(shadow_reg[REG_TEX_WIDTH]) / longint'(rect_wd);
      v = dy * longint'(shadow_reg[REG_TEX_HEIGHT]) / longint'(rect_ht);
    end
    d = longint'(y) * longint'(shadow_reg[REG_LINE_STRIDE]) + longint'(x);
    s = v * longint'(shadow_reg[REG_TEX_WIDTH]) + u;
    if (x + 1 >= win_r) begin
      pen_x = win_l;
      pen_y = y + 1;
      if (y + 1 >= win_b) begin
        walking = 1'b0;
        px.lst = 1'b1;
      end
    end else begin
      pen_x = x + 1;
    end
    px.dest = d[IDX_W-1:0];
    px.src = s[IDX_W-1:0];
    return 1'b1;
  endfunction

  function automatic longint window_size(input int l, t, r, b);
    int wl, wt, wr, wb;
    wl = (l > int'(shadow_reg[REG_CLIP_LEFT])) ? l : int'(shadow_reg[REG_CLIP_LEFT]);
    wt = (t > int'(shadow_reg[REG_CLIP_TOP])) ? t : int'(shadow_reg[REG_CLIP_TOP]);
    wr = (r < int'(shadow_reg[REG_CLIP_RIGHT])) ? r : int'(shadow_reg[REG_CLIP_RIGHT]);
    wb = (b < int'(shadow_reg[REG_CLIP_BOTTOM])) ? b : int'(shadow_reg[REG_CLIP_BOTTOM]);
    if (wl < wr && wt < wb) return longint'(wr - wl) * longint'(wb - wt);
    return 0;
  endfunction

  function automatic int pick_send_gap();
    int pick;
    if (tx_calm > 0) begin
      tx_calm--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 12);
    if (pick < 98) return $urandom_range(20, 60);
    tx_calm = $urandom_range(20, 80);
    return 0;
  endfunction

  function automatic int pick_scale();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 0;
    if (pick == 1) return 8191;
    return $urandom_range(1, 8191);
  endfunction

  task automatic report_mismatch(input string what, input logic [IDX_W-1:0] got,
                                 input logic [IDX_W-1:0] want);
    errors++;
    if (errors <= 40)
      $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  task automatic send_req(input logic kind, input logic signed [COORD_W-1:0] l, t, r, b,
                          output bit made, output pixel_t px);
    int gap;
    gap = pick_send_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    rect_left <= l;
    rect_top <= t;
    rect_right <= r;
    rect_bottom <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
    made = predict_pixel(kind, l, t, r, b, px);
  endtask

  task automatic offer(input logic kind, input logic signed [COORD_W-1:0] l, t, r, b,
                       output bit made);
    pixel_t px;
    send_req(kind, l, t, r, b, made, px);
    if (made) pixel_q.push_back(px);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_sets++;
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    shadow_reg[idx] = (idx == REG_ALIGNED_MODE) ? (data & 13'd1) : data;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // result side: check, then pick the stall for the next cycle
  always @(posedge clk) begin : result_side
    pixel_t want;
    int pick;
    if (!rst && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        report_mismatch("unexpected result, dest_index", dest_index, '0);
      end else begin
        want = pixel_q.pop_front();
        if (dest_index !== want.dest) report_mismatch("dest_index", dest_index, want.dest);
        if (src_index !== want.src) report_mismatch("src_index", src_index, want.src);
        if (last !== want.lst) report_mismatch("last", IDX_W'(last), IDX_W'(want.lst));
      end
      results_seen++;
    end
    if (results_seen == PRESSURE_AT && !squeezed) begin
      squeezed = 1'b1;
      rx_hold = PRESSURE_HOLD;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_stall <= 1'b1;
    end else if (rx_calm > 0) begin
      rx_calm--;
      out_stall <= 1'b0;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        out_stall <= 1'b0;
      end else if (pick < 88) begin
        rx_hold = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else if (pick < 95) begin
        rx_hold = $urandom_range(8, 50);
        out_stall <= 1'b1;
      end else begin
        rx_calm = $urandom_range(30, 200);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("Timeout: no beat for %0d cycles, %0d results outstanding",
               quiet, pixel_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    pixel_t px;
    bit made;
    int vals [8];
    int cl, ct, l, t, r, b, w, h, k, tries, phase_count, pick;
    longint n;

    shadow_reg[REG_CLIP_LEFT] = '0;
    shadow_reg[REG_CLIP_TOP] = '0;
    shadow_reg[REG_CLIP_RIGHT] = '0;
    shadow_reg[REG_CLIP_BOTTOM] = '0;
    shadow_reg[REG_LINE_STRIDE] = 13'd1;
    shadow_reg[REG_TEX_WIDTH] = 13'd1;
    shadow_reg[REG_TEX_HEIGHT] = 13'd1;
    shadow_reg[REG_ALIGNED_MODE] = '0;
    walking = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        if (i == 0 || plan[i-1].kind != ROW_CFG) quiesce();
        write_reg(REG_IDX_W'(plan[i].ridx), REG_W'(plan[i].rdata));
      end else begin
        send_req(1'(plan[i].req), COORD_W'(plan[i].l), COORD_W'(plan[i].t),
                 COORD_W'(plan[i].r), COORD_W'(plan[i].b), made, px);
        case (plan[i].chk)
          CHK_MODEL: if (made) pixel_q.push_back(px);
          CHK_GIVEN: pixel_q.push_back('{IDX_W'(plan[i].dest), IDX_W'(plan[i].src),
                                         1'(plan[i].lst)});
          default: ;
        endcase
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      quiesce();
      cl = $urandom_range(0, 8191);
      ct = $urandom_range(0, 8191);
      vals[REG_CLIP_LEFT] = cl;
      vals[REG_CLIP_TOP] = ct;
      vals[REG_CLIP_RIGHT] = ($urandom_range(0, 9) < 8) ?
                             ((cl + 48 > 8191) ? 8191 : cl + $urandom_range(1, 48)) :
                             $urandom_range(0, 8191);
      vals[REG_CLIP_BOTTOM] = ($urandom_range(0, 9) < 8) ?
                              ((ct + 24 > 8191) ? 8191 : ct + $urandom_range(1, 24)) :
                              $urandom_range(0, 8191);
      vals[REG_LINE_STRIDE] = pick_scale();
      vals[REG_TEX_WIDTH] = pick_scale();
      vals[REG_TEX_HEIGHT] = pick_scale();
      vals[REG_ALIGNED_MODE] = $urandom_range(0, 8191);
      if (ph == 0) vals = '{0, 0, 8191, 8191, 8191, 8191, 8191, 0};
      if (ph == 1) begin
        vals[REG_LINE_STRIDE] = 0;
        vals[REG_TEX_WIDTH] = 0;
        vals[REG_TEX_HEIGHT] = 0;
      end
      for (int i = 0; i < 8; i++) write_reg(REG_IDX_W'(i), REG_W'(vals[i]));

      phase_count = 0;
      while (phase_count < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 8) begin
          pick = $urandom_range(0, 1);
          offer(1'(pick), COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                COORD_W'($urandom), made);
          phase_count += (pick == 0 || made) ? 1 : 0;
        end else begin
          cl = int'(shadow_reg[REG_CLIP_LEFT]);
          ct = int'(shadow_reg[REG_CLIP_TOP]);
          tries = 0;
          do begin
            if ($urandom_range(0, 11) == 0) begin
              l = -int'($urandom_range(0, 32768));
              r = $urandom_range(0, 32767);
              t = -int'($urandom_range(0, 32768));
              b = $urandom_range(0, 32767);
            end else begin
              w = int'(shadow_reg[REG_CLIP_RIGHT]) - cl;
              h = int'(shadow_reg[REG_CLIP_BOTTOM]) - ct;
              l = cl + int'($urandom_range(0, (w > 0 ? w : 0) + 2)) - 2;
              t = ct + int'($urandom_range(0, (h > 0 ? h : 0) + 2)) - 2;
              r = l + int'($urandom_range(1, 6));
              b = t + int'($urandom_range(1, 4));
              if ($urandom_range(0, 4) == 0) l = l - int'($urandom_range(0, 20000));
              if ($urandom_range(0, 4) == 0) r = r + int'($urandom_range(0, 20000));
              if ($urandom_range(0, 4) == 0) t = t - int'($urandom_range(0, 20000));
              if ($urandom_range(0, 4) == 0) b = b + int'($urandom_range(0, 20000));
            end
            n = window_size(l, t, r, b);
            tries++;
          end while (n > MAX_WINDOW && tries < 8);
          if (n > MAX_WINDOW) begin
            l = cl;
            t = ct;
            r = cl + 1;
            b = ct + 1;
            n = window_size(l, t, r, b);
          end
          pick = $urandom_range(0, 99);
          if (n == 0) k = $urandom_range(0, 2);
          else if (pick < 70) k = int'(n) + (($urandom_range(0, 9) < 3) ? 1 : 0);
          else if (pick < 85) k = $urandom_range(0, int'(n) - 1);
          else k = int'(n) + $urandom_range(1, 3);
          offer(REQ_START, COORD_W'(l), COORD_W'(t), COORD_W'(r), COORD_W'(b), made);
          phase_count++;
          repeat (k) begin
            offer(REQ_ADVANCE, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                  COORD_W'($urandom), made);
            if (made) phase_count++;
          end
        end
      end
      // drop any walk still open before the next register settings
      offer(REQ_START, 16'sh7fff, COORD_W'($urandom), 16'sh8000, COORD_W'($urandom), made);
    end

    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d request beats and %0d pixel beats over %0d register settings,",
             items_sent, results_seen, cfg_sets);
    $display("scaled and aligned walks with clipping, restarts, idle advances and wrap.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
